// ===== hw/rtl/sspr_pkg.sv =====
package sspr_pkg;

    localparam int unsigned WIDTH = 62;
    localparam int unsigned CNT_W = 7;

    typedef logic [WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        RSN_PASS     = 3'd0,
        RSN_TWO      = 3'd1,
        RSN_BELOW    = 3'd2,
        RSN_EVEN     = 3'd3,
        RSN_JZERO    = 3'd4,
        RSN_MISMATCH = 3'd5
    } reason_t;

endpackage

// ===== hw/rtl/solovay_strassen_round_core.sv =====
// Channel | Dir | tdata fields (low bit up)             | tuser
// s_axis  | in  | candidate[61:0], witness[123:62]       | none
// m_axis  | out | composite[0], reason[3:1]              | none
//
// One beat is taken at a time; s_tready is low from acceptance until the result is taken.
// A candidate below three or an even one gives its result in the cycle after acceptance.
// The witness is reduced modulo the candidate bit-serially (ST_MOD_INIT, ST_MOD_STEP), as is each
// of up to about 1.5*WIDTH Jacobi remainders; each halving of the numerator is done in ST_JAC_EVEN.
// Each exponent bit squares the base, after multiplying it into the accumulator if the bit is set.
// Reset is synchronous and active low; a stalled result holds until m_tready is seen.
module solovay_strassen_round_core
    import sspr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // candidate[61:0], witness[123:62], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // composite[0], reason[3:1], zero pad
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD_INIT, ST_MOD_STEP, ST_JAC_EVEN, ST_JAC_SWAP,
        ST_POW_NEXT, ST_MUL_STEP, ST_DONE, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MR_WIT, MR_JAC
    } modsel_t;

    state_t      state_reg;
    modsel_t     msel_reg;
    word_t       n_reg, x_reg, m_reg, rem_reg, dvd_reg;
    word_t       base_reg, acc_reg, e_reg;
    word_t       mx_reg, my_reg, macc_reg;
    logic        mul_sq_reg;
    logic        sgn_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic        comp_reg;
    reason_t     why_reg;
    logic        mvalid_reg;

    // Shared unit: a + b (+ dividend MSB in ST_MOD_STEP), less m once if that reaches m.
    word_t       su_a, su_b, su_m, su_out;

    always_comb begin
        su_a = '0;
        su_b = '0;
        su_m = n_reg;
        unique case (state_reg)
            ST_MOD_STEP: begin
                su_a = rem_reg;
                su_b = rem_reg;
                su_m = m_reg;
            end
            ST_MUL_STEP: begin
                su_a = macc_reg;
                su_b = my_reg[0] ? mx_reg : '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [WIDTH:0] s1;
        s1 = {1'b0, su_a} + {1'b0, su_b};
        if (state_reg == ST_MOD_STEP) begin
            s1 = s1 | {{WIDTH{1'b0}}, dvd_reg[WIDTH-1]};
        end
        su_out = (s1 >= {1'b0, su_m}) ? WIDTH'(s1 - {1'b0, su_m}) : s1[WIDTH-1:0];
    end

    word_t dbl_x;
    logic [WIDTH:0] dbl_s;
    assign dbl_s = {mx_reg, 1'b0};
    assign dbl_x = (dbl_s >= {1'b0, n_reg}) ? WIDTH'(dbl_s - {1'b0, n_reg}) : mx_reg << 1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0000, why_reg, comp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        n_reg <= s_tdata[WIDTH-1:0];
                        dvd_reg <= s_tdata[62 +: WIDTH];
                        if (s_tdata[WIDTH-1:0] < word_t'(2)) begin
                            comp_reg <= 1'b1; why_reg <= RSN_BELOW; state_reg <= ST_OUT;
                            mvalid_reg <= 1'b1;
                        end else if (s_tdata[WIDTH-1:0] == word_t'(2)) begin
                            comp_reg <= 1'b0; why_reg <= RSN_TWO; state_reg <= ST_OUT;
                            mvalid_reg <= 1'b1;
                        end else if (!s_tdata[0]) begin
                            comp_reg <= 1'b1; why_reg <= RSN_EVEN; state_reg <= ST_OUT;
                            mvalid_reg <= 1'b1;
                        end else begin
                            m_reg <= s_tdata[WIDTH-1:0];
                            msel_reg <= MR_WIT;
                            sgn_reg <= 1'b0;
                            state_reg <= ST_MOD_INIT;
                        end
                    end
                end
                ST_MOD_INIT: begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(WIDTH);
                    state_reg <= ST_MOD_STEP;
                end
                ST_MOD_STEP: begin
                    rem_reg <= su_out;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        if (msel_reg == MR_WIT) begin
                            base_reg <= su_out;
                            x_reg <= su_out;
                        end else begin
                            x_reg <= su_out;
                        end
                        state_reg <= ST_JAC_EVEN;
                    end
                end
                ST_JAC_EVEN: begin
                    if (x_reg == '0) begin
                        if (m_reg == word_t'(1)) begin
                            acc_reg <= word_t'(1);
                            e_reg <= n_reg >> 1;
                            state_reg <= ST_POW_NEXT;
                        end else begin
                            comp_reg <= 1'b1; why_reg <= RSN_JZERO;
                            state_reg <= ST_OUT; mvalid_reg <= 1'b1;
                        end
                    end else if (!x_reg[0]) begin
                        x_reg <= x_reg >> 1;
                        if (m_reg[2:0] == 3'd3 || m_reg[2:0] == 3'd5) sgn_reg <= ~sgn_reg;
                    end else begin
                        state_reg <= ST_JAC_SWAP;
                    end
                end
                ST_JAC_SWAP: begin
                    if (x_reg[1:0] == 2'b11 && m_reg[1:0] == 2'b11) sgn_reg <= ~sgn_reg;
                    dvd_reg <= m_reg;
                    m_reg <= x_reg;
                    msel_reg <= MR_JAC;
                    state_reg <= ST_MOD_INIT;
                end
                ST_POW_NEXT: begin
                    if (e_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        macc_reg <= '0;
                        cnt_reg <= CNT_W'(WIDTH);
                        if (e_reg[0]) begin
                            mx_reg <= acc_reg; my_reg <= base_reg; mul_sq_reg <= 1'b0;
                        end else begin
                            mx_reg <= base_reg; my_reg <= base_reg; mul_sq_reg <= 1'b1;
                        end
                        state_reg <= ST_MUL_STEP;
                    end
                end
                ST_MUL_STEP: begin
                    if (cnt_reg == CNT_W'(1)) begin
                        if (!mul_sq_reg) begin
                            acc_reg <= su_out;
                            macc_reg <= '0;
                            mx_reg <= base_reg; my_reg <= base_reg; mul_sq_reg <= 1'b1;
                            cnt_reg <= CNT_W'(WIDTH);
                        end else begin
                            base_reg <= su_out;
                            e_reg <= e_reg >> 1;
                            state_reg <= ST_POW_NEXT;
                        end
                    end else begin
                        macc_reg <= su_out;
                        mx_reg <= dbl_x;
                        my_reg <= my_reg >> 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (acc_reg == (sgn_reg ? n_reg - word_t'(1) : word_t'(1))) begin
                        comp_reg <= 1'b0; why_reg <= RSN_PASS;
                    end else begin
                        comp_reg <= 1'b1; why_reg <= RSN_MISMATCH;
                    end
                    mvalid_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_ready_vs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input open while result pending");
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == ST_OUT) else $error("result outside output state");
    a_pass_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> comp_reg == (why_reg != RSN_PASS && why_reg != RSN_TWO))
        else $error("composite flag disagrees with reason");

endmodule
